// File: hw/rtl/seird_pkg.sv
package seird_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // register fields
  localparam int unsigned DIM_W  = 11;
  localparam int unsigned Q_W    = 16;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned POS_W  = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned SUM_W  = Q_W + CNT_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INFECTED_WT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_WT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_THR = 3'd4;

  // cell codes
  localparam logic [ST_W-1:0] ST_SUSCEPTIBLE = 3'd0;
  localparam logic [ST_W-1:0] ST_EXPOSED     = 3'd1;
  localparam logic [ST_W-1:0] ST_INFECTED    = 3'd2;
  localparam logic [ST_W-1:0] ST_RECOVERED   = 3'd3;
  localparam logic [ST_W-1:0] ST_DEAD        = 3'd4;

  typedef logic [8:0][ST_W-1:0] window_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

endpackage

// File: hw/rtl/seird_rule.sv
module seird_rule (
  input  seird_pkg::window_t              win_i,
  input  seird_pkg::border_t              border_i,
  input  logic [seird_pkg::Q_W-1:0]       infected_weight_i,
  input  logic [seird_pkg::Q_W-1:0]       dead_weight_i,
  input  logic [seird_pkg::Q_W-1:0]       recovery_threshold_i,
  input  logic [seird_pkg::Q_W-1:0]       rand_fraction_i,
  output logic [seird_pkg::ST_W-1:0]      next_state_o
);
  import seird_pkg::*;

  logic [CNT_W-1:0] n_inf;
  logic [CNT_W-1:0] n_dead;
  logic [SUM_W-1:0] exposure;
  logic [8:0]       use_nb;

  // neighbor mask: drop center and positions outside the grid
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      use_nb[k] = (k != 4);
      if (k < 3 && border_i.top) use_nb[k] = 1'b0;
      if (k > 5 && border_i.bottom) use_nb[k] = 1'b0;
      if ((k % 3) == 0 && border_i.left) use_nb[k] = 1'b0;
      if ((k % 3) == 2 && border_i.right) use_nb[k] = 1'b0;
    end
  end

  always_comb begin
    n_inf  = '0;
    n_dead = '0;
    for (int k = 0; k < 9; k++) begin
      if (use_nb[k] && win_i[k] == ST_INFECTED) n_inf = n_inf + 1'b1;
      if (use_nb[k] && win_i[k] == ST_DEAD) n_dead = n_dead + 1'b1;
    end
  end

  assign exposure = (SUM_W'(n_inf) * SUM_W'(infected_weight_i))
                  + (SUM_W'(n_dead) * SUM_W'(dead_weight_i));

  always_comb begin
    unique case (win_i[4])
      ST_SUSCEPTIBLE: next_state_o = (n_inf != '0) ? ST_EXPOSED : ST_SUSCEPTIBLE;
      ST_EXPOSED:     next_state_o = (exposure > SUM_W'(rand_fraction_i)) ? ST_INFECTED
                                                                         : ST_EXPOSED;
      ST_INFECTED:    next_state_o = (recovery_threshold_i > rand_fraction_i) ? ST_RECOVERED
                                                                             : ST_DEAD;
      default:        next_state_o = win_i[4];
    endcase
  end

endmodule

// File: hw/rtl/seird_cellular_automaton_step_core.sv
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------------
// in       | in_valid_i / in_ready_o    | cell_state_i, rand_fraction_i, flush_i
// out      | out_valid_o / out_ready_i  | next_state_o, grid_done_o
// cfg      | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// one word per cycle sustained while the output is taken; a word enters the middle stage at acceptance
// (row memory read), then window update, rule and write-back carry it into the output register.
// the result for a cell lags its input by grid width plus one words.
// reset clears control, configuration, position and window; data registers and the row memory are not cleared.
// a held output stalls the middle stage when it holds a releasing word, and then the input, nothing else.
module seird_cellular_automaton_step_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [seird_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [seird_pkg::Q_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [seird_pkg::ST_W-1:0]        cell_state_i,
  input  logic [seird_pkg::Q_W-1:0]         rand_fraction_i,
  input  logic                              flush_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [seird_pkg::ST_W-1:0]        next_state_o,
  output logic                              grid_done_o
);
  import seird_pkg::*;

  // configuration
  logic [DIM_W-1:0] grid_width_q, grid_height_q;
  logic [Q_W-1:0]   infected_weight_q, dead_weight_q, recovery_threshold_q;
  logic             restart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q         <= DIM_W'(1024);
      grid_height_q        <= DIM_W'(1024);
      infected_weight_q    <= Q_W'(19661);
      dead_weight_q        <= Q_W'(3277);
      recovery_threshold_q <= Q_W'(32768);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_WIDTH:   grid_width_q <= cfg_data_i[DIM_W-1:0];
        REG_GRID_HEIGHT:  grid_height_q <= cfg_data_i[DIM_W-1:0];
        REG_INFECTED_WT:  infected_weight_q <= cfg_data_i;
        REG_DEAD_WT:      dead_weight_q <= cfg_data_i;
        REG_RECOVERY_THR: recovery_threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i && (cfg_idx_i == REG_GRID_WIDTH || cfg_idx_i == REG_GRID_HEIGHT);

  logic [POS_W-1:0] w_used;
  logic [DIM_W-1:0] h_used;

  always_comb begin
    priority if (POS_W'(grid_width_q) < POS_W'(3)) w_used = POS_W'(3);
    else if (POS_W'(grid_width_q) > POS_W'(MAX_WIDTH)) w_used = POS_W'(MAX_WIDTH);
    else w_used = POS_W'(grid_width_q);
    priority if (grid_height_q < DIM_W'(3)) h_used = DIM_W'(3);
    else if (grid_height_q > DIM_W'(MAX_HEIGHT)) h_used = DIM_W'(MAX_HEIGHT);
    else h_used = grid_height_q;
  end

  // input stage: position tracking
  logic [DIM_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic [COL_W-1:0] col;
  logic [POS_W-1:0] col_inc, ocol_inc;
  logic             draining, take, push, rel, done;
  logic [ST_W-1:0]  in_cell;
  border_t          border;

  assign take     = in_valid_i && in_ready_o;
  assign draining = in_row_q >= h_used;
  assign push     = take && (draining || !flush_i);
  assign in_cell  = draining ? ST_SUSCEPTIBLE : cell_state_i;
  assign col      = (POS_W'(in_col_q) < w_used) ? in_col_q : '0;
  assign col_inc  = POS_W'(col) + POS_W'(1);
  assign rel      = !(in_row_q == '0 || (in_row_q == DIM_W'(1) && col == '0));
  assign done     = rel && (in_row_q == h_used + DIM_W'(1)) && col == '0;
  assign ocol_inc = POS_W'(out_col_q) + POS_W'(1);

  assign border.top    = out_row_q == '0;
  assign border.bottom = DIM_W'(out_row_q) == h_used - DIM_W'(1);
  assign border.left   = out_col_q == '0;
  assign border.right  = ocol_inc == w_used;

  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (restart) begin
      in_row_d  = '0;
      in_col_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
    end else if (push) begin
      if (done) begin
        in_row_d  = '0;
        in_col_d  = '0;
        out_row_d = '0;
        out_col_d = '0;
      end else begin
        if (col_inc >= w_used) begin
          in_col_d = '0;
          in_row_d = in_row_q + DIM_W'(1);
        end else begin
          in_col_d = col_inc[COL_W-1:0];
        end
        if (rel) begin
          if (ocol_inc >= w_used) begin
            out_col_d = '0;
            out_row_d = out_row_q + ROW_W'(1);
          end else begin
            out_col_d = ocol_inc[COL_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
    end
  end

  // middle stage: row memory data, window, rule
  logic             s1_valid_q, s1_rel_q, s1_done_q, s1_adv;
  logic [ST_W-1:0]  s1_cell_q;
  logic [Q_W-1:0]   s1_rand_q;
  logic [COL_W-1:0] s1_col_q;
  border_t          s1_border_q;
  logic [2*ST_W-1:0] rd_q;
  logic              out_valid_q, out_done_q;
  logic [ST_W-1:0]   out_state_q, rule_state;

  assign s1_adv     = s1_valid_q && (!s1_rel_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      s1_cell_q   <= in_cell;
      s1_rand_q   <= rand_fraction_i;
      s1_col_q    <= col;
      s1_rel_q    <= rel;
      s1_done_q   <= done;
      s1_border_q <= border;
    end
  end

  // row memory: each entry holds {two rows up, one row up} for its column
  logic [2*ST_W-1:0] row_mem [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      row_mem[s1_col_q] <= {rd_q[ST_W-1:0], s1_cell_q};
    end
    if (push) begin
      rd_q <= row_mem[col];
    end
  end

  window_t win_q, win_n;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_n[r*3]     = win_q[r*3+1];
      win_n[r*3 + 1] = win_q[r*3+2];
    end
    win_n[2] = rd_q[2*ST_W-1:ST_W];
    win_n[5] = rd_q[ST_W-1:0];
    win_n[8] = s1_cell_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q <= win_n;
    end
  end

  seird_rule u_rule (
    .win_i               (win_n),
    .border_i            (s1_border_q),
    .infected_weight_i   (infected_weight_q),
    .dead_weight_i       (dead_weight_q),
    .recovery_threshold_i(recovery_threshold_q),
    .rand_fraction_i     (s1_rand_q),
    .next_state_o        (rule_state)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_rel_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_rel_q) begin
      out_state_q <= rule_state;
      out_done_q  <= s1_done_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_state_o = out_state_q;
  assign grid_done_o  = out_done_q;

endmodule

// File: test/seird_cellular_automaton_step_core_test.sv
import seird_pkg::*;

class seird_step_scoreboard;
  bit [DIM_W-1:0]  grid_width;
  bit [DIM_W-1:0]  grid_height;
  bit [Q_W-1:0]    infected_wt;
  bit [Q_W-1:0]    dead_wt;
  bit [Q_W-1:0]    recovery_thr;
  // lower half: last row written, upper half: the row before
  bit [ST_W-1:0]   line_mem [2*MAX_WIDTH];
  bit [ST_W-1:0]   win [9];
  int unsigned     in_row;
  int unsigned     in_col;
  int unsigned     out_count;
  bit [ST_W-1:0]   expected_state [$];
  bit              expected_done [$];
  int unsigned     mismatches;

  function new();
    grid_width   = DIM_W'(1024);
    grid_height  = DIM_W'(1024);
    infected_wt  = Q_W'(19661);
    dead_wt      = Q_W'(3277);
    recovery_thr = Q_W'(32768);
    in_row       = 0;
    in_col       = 0;
    out_count    = 0;
    mismatches   = 0;
  endfunction

  function int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function void restart_grid();
    in_row    = 0;
    in_col    = 0;
    out_count = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] data);
    case (idx)
      REG_GRID_WIDTH: begin
        grid_width = data[DIM_W-1:0];
        restart_grid();
      end
      REG_GRID_HEIGHT: begin
        grid_height = data[DIM_W-1:0];
        restart_grid();
      end
      REG_INFECTED_WT:  infected_wt = data;
      REG_DEAD_WT:      dead_wt = data;
      REG_RECOVERY_THR: recovery_thr = data;
      default: ;
    endcase
  endfunction

  function bit grid_draining();
    return in_row >= clamp_dim(grid_height, MAX_HEIGHT);
  endfunction

  function int unsigned pending();
    return expected_state.size();
  endfunction

  function bit [ST_W-1:0] next_cell_state(int unsigned w, int unsigned h, bit [Q_W-1:0] rnd);
    int unsigned crow;
    int unsigned ccol;
    int unsigned n_inf;
    int unsigned n_dead;
    int unsigned sum;
    int          dr;
    int          dc;
    bit [ST_W-1:0] s;
    crow   = out_count / w;
    ccol   = out_count % w;
    n_inf  = 0;
    n_dead = 0;
    for (dr = 0; dr < 3; dr++) begin
      for (dc = 0; dc < 3; dc++) begin
        // neighbours off the grid edge are not counted
        if (!((dr == 1 && dc == 1) || (dr == 0 && crow == 0) || (dr == 2 && crow + 1 == h) ||
              (dc == 0 && ccol == 0) || (dc == 2 && ccol + 1 == w))) begin
          s = win[dr*3 + dc];
          if (s == ST_INFECTED) n_inf++;
          else if (s == ST_DEAD) n_dead++;
        end
      end
    end
    case (win[4])
      ST_SUSCEPTIBLE: return (n_inf > 0) ? ST_EXPOSED : ST_SUSCEPTIBLE;
      ST_EXPOSED: begin
        sum = n_inf * infected_wt + n_dead * dead_wt;
        return (sum > rnd) ? ST_INFECTED : ST_EXPOSED;
      end
      ST_INFECTED: return (recovery_thr > rnd) ? ST_RECOVERED : ST_DEAD;
      default: return win[4];
    endcase
  endfunction

  function void take_word(bit [ST_W-1:0] cs, bit [Q_W-1:0] rnd, bit fl);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned pos;
    int          r;
    bit [ST_W-1:0] in_cell;
    bit [ST_W-1:0] older;
    bit [ST_W-1:0] newer;
    bit            done_flag;
    w = clamp_dim(grid_width, MAX_WIDTH);
    h = clamp_dim(grid_height, MAX_HEIGHT);
    // a flush inside the grid does nothing at all
    if (in_row < h && fl) return;
    in_cell = (in_row >= h) ? ST_SUSCEPTIBLE : cs;
    col     = (in_col < w) ? in_col : 0;
    older   = line_mem[MAX_WIDTH + col];
    newer   = line_mem[col];
    for (r = 0; r < 3; r++) begin
      win[r*3]     = win[r*3 + 1];
      win[r*3 + 1] = win[r*3 + 2];
    end
    win[2] = older;
    win[5] = newer;
    win[8] = in_cell;
    line_mem[MAX_WIDTH + col] = newer;
    line_mem[col]             = in_cell;
    pos    = in_row * w + col;
    in_col = col + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (pos < w + 1) return;
    expected_state.push_back(next_cell_state(w, h, rnd));
    out_count++;
    done_flag = (out_count >= w * h);
    if (done_flag) restart_grid();
    expected_done.push_back(done_flag);
  endfunction

  task report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_result(logic [ST_W-1:0] ns, logic gd);
    bit [ST_W-1:0] want_state;
    bit            want_done;
    if (expected_state.size() == 0) begin
      report_mismatch($sformatf("unexpected word next_state=%0d grid_done=%0d", ns, gd));
      return;
    end
    want_state = expected_state.pop_front();
    want_done  = expected_done.pop_front();
    if (ns !== want_state)
      report_mismatch($sformatf("next_state %0d, want %0d", ns, want_state));
    if (gd !== want_done)
      report_mismatch($sformatf("grid_done %0d, want %0d", gd, want_done));
  endtask
endclass

module seird_cellular_automaton_step_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import seird_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_GAP     = 40;
  localparam logic [ST_W-1:0] ST_SPARE_LO = 3'd5;
  localparam logic [ST_W-1:0] ST_SPARE_HI = 3'd7;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i       = '0;
  logic [Q_W-1:0]       cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  logic [ST_W-1:0]      cell_state_i    = '0;
  logic [Q_W-1:0]       rand_fraction_i = '0;
  logic                 flush_i         = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  logic [ST_W-1:0]      next_state_o;
  logic                 grid_done_o;

  seird_step_scoreboard sb;
  int unsigned          send_idle_pct  = 0;
  int unsigned          recv_stall_pct = 0;
  int unsigned          idle_cycles    = 0;

  seird_cellular_automaton_step_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cell_state_i   (cell_state_i),
    .rand_fraction_i(rand_fraction_i),
    .flush_i        (flush_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .next_state_o   (next_state_o),
    .grid_done_o    (grid_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(next_state_o, grid_done_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(logic [ST_W-1:0] cs, logic [Q_W-1:0] rnd, logic fl);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cell_state_i    <= cs;
    rand_fraction_i <= rnd;
    flush_i         <= fl;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sb.take_word(cs, rnd, fl);
  endtask

  // also covers the pipeline tail of words that release nothing
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned n_words);
    int unsigned     taken;
    int unsigned     pick;
    logic [ST_W-1:0] cs;
    logic [Q_W-1:0]  rnd;
    logic            fl;
    taken = 0;
    while (taken < n_words) begin
      case ($urandom_range(7))
        0: rnd = '0;
        1: rnd = '1;
        2: rnd = sb.infected_wt;
        3: rnd = sb.recovery_thr;
        default: rnd = Q_W'($urandom_range(16'hFFFF));
      endcase
      pick = $urandom_range(99);
      if (sb.grid_draining()) begin
        // past the last cell any word only drains
        cs = ST_W'($urandom_range(7));
        fl = 1'($urandom_range(1));
        taken++;
      end else if (pick < 5) begin
        cs = ST_W'($urandom_range(7));
        fl = 1'b1;
      end else begin
        pick = $urandom_range(99);
        if (pick < 30) cs = ST_SUSCEPTIBLE;
        else if (pick < 55) cs = ST_EXPOSED;
        else if (pick < 75) cs = ST_INFECTED;
        else if (pick < 85) cs = ST_RECOVERED;
        else if (pick < 95) cs = ST_DEAD;
        else cs = ST_W'($urandom_range(ST_SPARE_LO, ST_SPARE_HI));
        fl = 1'b0;
        taken++;
      end
      send_word(cs, rnd, fl);
      if ($urandom_range(149) == 0) hold_until_drained();
    end
  endtask

  task automatic run_phase(bit resize, logic [Q_W-1:0] w, logic [Q_W-1:0] h,
                           logic [Q_W-1:0] iw, logic [Q_W-1:0] dw, logic [Q_W-1:0] rt,
                           int unsigned send_pct, int unsigned stall_pct,
                           int unsigned n_words);
    hold_until_drained();
    if (resize) begin
      set_reg(REG_GRID_WIDTH, w);
      set_reg(REG_GRID_HEIGHT, h);
    end
    set_reg(REG_INFECTED_WT, iw);
    set_reg(REG_DEAD_WT, dw);
    set_reg(REG_RECOVERY_THR, rt);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    run_random(n_words);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3 grid from sizes below range, weights left at reset
    set_reg(REG_GRID_WIDTH, 16'd0);
    set_reg(REG_GRID_HEIGHT, 16'd2);
    send_word(ST_SUSCEPTIBLE, 16'hFFFF, 1'b1);
    send_word(ST_INFECTED, 16'd0, 1'b0);
    send_word(ST_EXPOSED, 16'hFFFF, 1'b0);
    send_word(ST_SUSCEPTIBLE, 16'd0, 1'b0);
    send_word(ST_EXPOSED, 16'hFFFF, 1'b0);
    // rand_fraction below serves the cell released by this word
    send_word(ST_INFECTED, 16'd32768, 1'b0);
    send_word(ST_DEAD, 16'd42599, 1'b0);
    send_word(ST_DEAD, 16'd0, 1'b1);
    send_word(ST_SPARE_HI, 16'd1, 1'b0);
    send_word(ST_RECOVERED, 16'd39321, 1'b0);
    send_word(ST_SPARE_LO, 16'd32767, 1'b0);
    send_word(ST_DEAD, 16'hFFFF, 1'b0);
    send_word(ST_SUSCEPTIBLE, 16'd0, 1'b1);
    send_word(ST_INFECTED, 16'd19661, 1'b0);
    send_word(ST_SPARE_HI, 16'h8000, 1'b1);

    run_phase(1'b1, 16'd3, 16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 70);
    run_phase(1'b1, 16'd5, 16'd4, 16'd0, 16'd0, 16'd0, 73, 0, 70);
    run_phase(1'b1, 16'd7, 16'd3, 16'd19661, 16'd3277, 16'd32768, 0, 73, 70);
    // weights only, grid keeps going
    run_phase(1'b0, 16'd7, 16'd3, Q_W'($urandom), Q_W'($urandom), Q_W'($urandom),
              33, 33, 70);
    // widest rows and sizes above and below range, only the start of each grid
    run_phase(1'b1, 16'd1024, 16'd3, Q_W'($urandom), Q_W'($urandom), Q_W'($urandom),
              0, 0, 40);
    run_phase(1'b1, 16'd1, 16'd2047, Q_W'($urandom), Q_W'($urandom), Q_W'($urandom),
              33, 33, 25);
    run_phase(1'b1, 16'hFFFF, 16'd1, Q_W'($urandom), Q_W'($urandom), Q_W'($urandom),
              0, 73, 25);
    run_phase(1'b1, Q_W'($urandom_range(3, 12)), Q_W'($urandom_range(3, 8)),
              Q_W'($urandom_range(16'hFFFF)), Q_W'($urandom_range(16'hFFFF)),
              Q_W'($urandom_range(16'hFFFF)), 73, 0, 30);

    hold_until_drained();
    repeat (16) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: seird_cellular_automaton_step_core.f
hw/rtl/seird_pkg.sv
hw/rtl/seird_rule.sv
hw/rtl/seird_cellular_automaton_step_core.sv
test/seird_cellular_automaton_step_core_test.sv
